[rtl/rfp_pkg.sv]
package rfp_pkg;

	// Frame delimiters, in the order in which they arrive on the link.
	localparam logic [7:0] HDR_B0 = 8'hF4;
	localparam logic [7:0] HDR_B1 = 8'hF3;
	localparam logic [7:0] HDR_B2 = 8'hF2;
	localparam logic [7:0] HDR_B3 = 8'hF1;
	localparam logic [7:0] FTR_B0 = 8'hF8;
	localparam logic [7:0] FTR_B1 = 8'hF7;
	localparam logic [7:0] FTR_B2 = 8'hF6;
	localparam logic [7:0] FTR_B3 = 8'hF5;

	// Shortest frame that is taken as valid, and the offset of the target state byte.
	localparam int MIN_FRAME = 20;
	localparam int STATE_POS = 8;
	localparam int DELIM_LEN = 4;

	// Target state codes.
	localparam logic [7:0] TS_NONE       = 8'h00;
	localparam logic [7:0] TS_MOVING     = 8'h01;
	localparam logic [7:0] TS_STATIONARY = 8'h02;
	localparam logic [7:0] TS_BOTH       = 8'h03;

	typedef struct packed {
		logic       frame_accepted;
		logic       presence;
		logic       moving_target;
		logic       stationary_target;
		logic [7:0] target_state;
		logic [5:0] frame_length;
	} res_t;

	// Expected header byte at a given position within the header.
	function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = HDR_B0;
			2'd1: b = HDR_B1;
			2'd2: b = HDR_B2;
			default: b = HDR_B3;
		endcase
		return b;
	endfunction

endpackage

[rtl/rfp_frame_track.sv]
module rfp_frame_track #(
	parameter int PASS_BYTES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        rx_byte,
	output logic              push,
	output rfp_pkg::res_t     res
);

	localparam int CW = $clog2(PASS_BYTES);
	localparam logic [CW:0] PASS_N = (CW + 1)'(PASS_BYTES);
	localparam logic [CW:0] N_MIN  = (CW + 1)'(rfp_pkg::MIN_FRAME);
	localparam logic [CW:0] N_DLM  = (CW + 1)'(rfp_pkg::DELIM_LEN);
	localparam logic [CW:0] N_POS8 = (CW + 1)'(rfp_pkg::STATE_POS);
	localparam logic [CW-1:0] P_POS8 = CW'(rfp_pkg::STATE_POS);
	localparam logic [CW-1:0] P_DLM  = CW'(rfp_pkg::DELIM_LEN);

	logic [CW-1:0] count_q;
	logic          header_ok_q;
	logic [7:0]    state_byte_q;
	logic [7:0]    recent_q [3];
	logic          presence_q;
	logic          moving_q;
	logic          stationary_q;

	logic [CW:0]   n_raw;
	logic [CW-1:0] n_wrap;
	logic          hdr_nxt;
	logic [7:0]    sb_nxt;
	logic          footer;
	logic          accepted;
	logic [7:0]    ts;
	logic          pres_nxt;
	logic          mov_nxt;
	logic          stat_nxt;

	always_comb begin
		hdr_nxt = header_ok_q;
		if (count_q == '0) begin
			hdr_nxt = (rx_byte == rfp_pkg::HDR_B0);
		end else if (count_q < P_DLM) begin
			hdr_nxt = header_ok_q && (rx_byte == rfp_pkg::hdr_byte(count_q[1:0]));
		end
		sb_nxt = (count_q == P_POS8) ? rx_byte : state_byte_q;

		n_raw  = {1'b0, count_q} + (CW + 1)'(1);
		n_wrap = (n_raw == PASS_N) ? '0 : n_raw[CW-1:0];

		// A wrapped count reads as zero and so can never close a frame.
		footer = (n_raw != PASS_N) && (n_raw >= N_DLM) &&
			(recent_q[2] == rfp_pkg::FTR_B0) && (recent_q[1] == rfp_pkg::FTR_B1) &&
			(recent_q[0] == rfp_pkg::FTR_B2) && (rx_byte == rfp_pkg::FTR_B3);

		accepted = (n_raw >= N_MIN) && hdr_nxt;
		ts       = (n_raw > N_POS8) ? sb_nxt : rfp_pkg::TS_NONE;

		pres_nxt = presence_q;
		mov_nxt  = moving_q;
		stat_nxt = stationary_q;
		if (accepted) begin
			pres_nxt = (ts != rfp_pkg::TS_NONE);
			mov_nxt  = (ts == rfp_pkg::TS_MOVING) || (ts == rfp_pkg::TS_BOTH);
			stat_nxt = (ts == rfp_pkg::TS_STATIONARY) || (ts == rfp_pkg::TS_BOTH);
		end

		push                  = take && footer;
		res.frame_accepted    = accepted;
		res.presence          = pres_nxt;
		res.moving_target     = mov_nxt;
		res.stationary_target = stat_nxt;
		res.target_state      = ts;
		res.frame_length      = n_raw[5:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			header_ok_q  <= 1'b0;
			state_byte_q <= '0;
			recent_q[0]  <= '0;
			recent_q[1]  <= '0;
			recent_q[2]  <= '0;
			presence_q   <= 1'b0;
			moving_q     <= 1'b0;
			stationary_q <= 1'b0;
		end else if (take) begin
			count_q      <= footer ? '0 : n_wrap;
			header_ok_q  <= hdr_nxt;
			state_byte_q <= sb_nxt;
			recent_q[0]  <= rx_byte;
			recent_q[1]  <= recent_q[0];
			recent_q[2]  <= recent_q[1];
			if (footer) begin
				presence_q   <= pres_nxt;
				moving_q     <= mov_nxt;
				stationary_q <= stat_nxt;
			end
		end
	end

endmodule

[rtl/rfp_out_buf.sv]
module rfp_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rfp_pkg::res_t res_in,
	input  logic          res_stall,
	output logic          res_valid,
	output logic          full,
	output rfp_pkg::res_t res_out
);

	logic          valid_q;
	logic          skid_valid_q;
	rfp_pkg::res_t main_q;
	rfp_pkg::res_t skid_q;
	logic          pop;

	assign pop       = valid_q && !res_stall;
	assign res_valid = valid_q;
	assign full      = skid_valid_q;
	assign res_out   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!valid_q || pop) begin
				valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (!valid_q || pop) begin
				main_q <= res_in;
			end else begin
				skid_q <= res_in;
			end
		end
	end

`ifndef SYNTHESIS
	a_skid_implies_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> valid_q)
		else $error("skid entry held while main entry empty");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && skid_valid_q))
		else $error("result pushed into a full buffer");

	a_accept_sets_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && main_q.frame_accepted) |->
		(main_q.presence == (main_q.target_state != rfp_pkg::TS_NONE)) &&
		(main_q.moving_target == ((main_q.target_state == rfp_pkg::TS_MOVING) ||
			(main_q.target_state == rfp_pkg::TS_BOTH))))
		else $error("accepted frame flags disagree with target state");
`endif

endmodule

[rtl/radar_frame_target_parser.sv]
// Channel | Handshake          | Payload
// rx      | rx_valid, rx_stall | rx_byte[7:0]
// res     | res_valid, res_stall | frame_accepted, presence, moving_target,
//         |                    | stationary_target, target_state[7:0], frame_length[5:0]
//
// One byte is taken every cycle while rx_stall is low; a result is registered from the footer byte.
// The frame tracker updates its count, header check and delimiter history on each
// byte transfer, so the per-byte path is one small add and a few byte compares.
// Reset (arst_n low) clears the count, header check, history and held flags.
// The result side holds a main register and a skid register; rx_stall rises only
// when both are occupied, so a single stalled result never blocks the next byte.
module radar_frame_target_parser #(
	parameter int PASS_BYTES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       frame_accepted,
	output logic       presence,
	output logic       moving_target,
	output logic       stationary_target,
	output logic [7:0] target_state,
	output logic [5:0] frame_length
);

	logic          rx_fire;
	logic          push;
	logic          full;
	rfp_pkg::res_t res_new;
	rfp_pkg::res_t res_cur;

	// A byte transfer happens whenever rx_valid is high and the skid register is free;
	// the stall is taken straight from a register, so it never depends on rx_valid.
	assign rx_stall = full;
	assign rx_fire  = rx_valid && !full;

	// Frame tracking: pass position, header match, target state capture and
	// footer detection. It flags a result on the byte that completes a footer.
	rfp_frame_track #(
		.PASS_BYTES(PASS_BYTES)
	) u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (rx_fire),
		.rx_byte (rx_byte),
		.push    (push),
		.res     (res_new)
	);

	// Result register with skid entry toward the consumer.
	rfp_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.res_in    (res_new),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.full      (full),
		.res_out   (res_cur)
	);

	assign frame_accepted    = res_cur.frame_accepted;
	assign presence          = res_cur.presence;
	assign moving_target     = res_cur.moving_target;
	assign stationary_target = res_cur.stationary_target;
	assign target_state      = res_cur.target_state;
	assign frame_length      = res_cur.frame_length;

endmodule

[tb/radar_frame_target_parser_tb.sv]
`timescale 1ns / 1ps

module radar_frame_target_parser_tb;

	localparam int PASS = 64;
	// Generous bound: about six hundred bytes, each with at most a long gap,
	// plus a long receiver stall on every result and the one deliberate hold.
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;

	localparam logic [7:0] HDR_SEQ [4] = '{rfp_pkg::HDR_B0, rfp_pkg::HDR_B1,
		rfp_pkg::HDR_B2, rfp_pkg::HDR_B3};
	localparam logic [7:0] FTR_SEQ [4] = '{rfp_pkg::FTR_B0, rfp_pkg::FTR_B1,
		rfp_pkg::FTR_B2, rfp_pkg::FTR_B3};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       rx_valid = 1'b0;
	logic       rx_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic       frame_accepted;
	logic       presence;
	logic       moving_target;
	logic       stationary_target;
	logic [7:0] target_state;
	logic [5:0] frame_length;

	radar_frame_target_parser #(
		.PASS_BYTES(PASS)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.rx_valid         (rx_valid),
		.rx_stall         (rx_stall),
		.rx_byte          (rx_byte),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.frame_accepted   (frame_accepted),
		.presence         (presence),
		.moving_target    (moving_target),
		.stationary_target(stationary_target),
		.target_state     (target_state),
		.frame_length     (frame_length)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Our own copy of the frame tracker. It is advanced once per accepted byte
	// transfer and pushes one expected frame report whenever a footer closes.
	int         trk_count;
	logic       trk_hdr_ok;
	logic [7:0] trk_state;
	logic [7:0] trk_hist [3];
	logic       trk_presence;
	logic       trk_moving;
	logic       trk_stationary;

	rfp_pkg::res_t frame_reports_q [$];
	int   frames_predicted;
	int   bytes_sent;
	int   errors;
	int   cycle_count;

	// When calm is set, neither side idles, so some stretches run back to back.
	bit calm;
	// Cycles left in a deliberate receiver hold-off; counted down by the
	// receiver process.
	int hold_left;

	task automatic track_byte(input logic [7:0] b);
		int            pos;
		int            n;
		logic          footer_hit;
		logic          accepted;
		logic [7:0]    ts;
		rfp_pkg::res_t r;
		pos = trk_count;
		if (pos >= PASS) begin
			pos = 0;
		end
		// The header check restarts at position zero and only narrows over the
		// next three bytes.
		if (pos == 0) begin
			trk_hdr_ok = (b == HDR_SEQ[0]);
		end else if (pos < rfp_pkg::DELIM_LEN) begin
			trk_hdr_ok = trk_hdr_ok && (b == HDR_SEQ[pos]);
		end
		if (pos == rfp_pkg::STATE_POS) begin
			trk_state = b;
		end
		n = pos + 1;
		if (n >= PASS) begin
			n = 0;
		end
		// A footer only counts when all four of its bytes lie in this pass,
		// so the byte that wraps the count can never close a frame.
		footer_hit = (n >= rfp_pkg::DELIM_LEN) && (trk_hist[2] == FTR_SEQ[0]) &&
			(trk_hist[1] == FTR_SEQ[1]) && (trk_hist[0] == FTR_SEQ[2]) &&
			(b == FTR_SEQ[3]);
		trk_hist[2] = trk_hist[1];
		trk_hist[1] = trk_hist[0];
		trk_hist[0] = b;
		if (footer_hit) begin
			accepted = (n >= rfp_pkg::MIN_FRAME) && trk_hdr_ok;
			// A frame too short to hold the state byte reports zero there.
			ts = (n > rfp_pkg::STATE_POS) ? trk_state : rfp_pkg::TS_NONE;
			if (accepted) begin
				trk_presence   = (ts != rfp_pkg::TS_NONE);
				trk_moving     = (ts == rfp_pkg::TS_MOVING) || (ts == rfp_pkg::TS_BOTH);
				trk_stationary = (ts == rfp_pkg::TS_STATIONARY) ||
					(ts == rfp_pkg::TS_BOTH);
			end
			r.frame_accepted    = accepted;
			r.presence          = trk_presence;
			r.moving_target     = trk_moving;
			r.stationary_target = trk_stationary;
			r.target_state      = ts;
			r.frame_length      = n[5:0];
			frame_reports_q.push_back(r);
			frames_predicted++;
			n = 0;
		end
		trk_count = n;
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// Offers one byte at the falling edge and holds it until a rising edge
	// finds rx_stall low, which completes the transfer. An idle gap may follow.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		int pick;
		@(negedge clk);
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do begin
			@(posedge clk);
		end while (rx_stall);
		track_byte(b);
		bytes_sent++;
		gap = 0;
		if (!calm) begin
			pick = $urandom_range(0, 99);
			if (pick >= 95) begin
				gap = $urandom_range(10, 30);
			end else if (pick >= 70) begin
				gap = $urandom_range(1, 3);
			end
		end
		if (gap > 0) begin
			@(negedge clk);
			rx_valid <= 1'b0;
			rx_byte  <= 8'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Builds one frame of the given length. The header goes in first and the
	// state byte at its offset, and the footer is written last, so in short
	// frames it overwrites whatever would have overlapped it.
	task automatic send_frame(input int len, input bit good_hdr, input logic [7:0] ts);
		logic [7:0] buf_bytes [PASS];
		int         bad_pos;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				buf_bytes[i] = 8'($urandom_range(8'hF0, 8'hFF));
			end else begin
				buf_bytes[i] = 8'($urandom);
			end
		end
		for (int i = 0; i < rfp_pkg::DELIM_LEN && i < len; i++) begin
			buf_bytes[i] = HDR_SEQ[i];
		end
		if (!good_hdr) begin
			bad_pos = $urandom_range(0, rfp_pkg::DELIM_LEN - 1);
			buf_bytes[bad_pos] = buf_bytes[bad_pos] ^ 8'(1 << $urandom_range(0, 7));
		end
		if (len > rfp_pkg::STATE_POS) begin
			buf_bytes[rfp_pkg::STATE_POS] = ts;
		end
		for (int i = 0; i < rfp_pkg::DELIM_LEN; i++) begin
			buf_bytes[len - rfp_pkg::DELIM_LEN + i] = FTR_SEQ[i];
		end
		for (int i = 0; i < len; i++) begin
			send_byte(buf_bytes[i]);
		end
	endtask

	// Result side: random stalls in runs, mostly short and a few long, unless
	// a hold-off is in progress or the run is in a calm stretch.
	int stall_run;
	always @(negedge clk) begin
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (calm) begin
			res_stall <= 1'b0;
			stall_run = 0;
		end else if (stall_run > 0) begin
			stall_run = stall_run - 1;
		end else begin
			res_stall <= ($urandom_range(0, 1) == 1);
			if ($urandom_range(0, 9) == 0) begin
				stall_run = $urandom_range(10, 40);
			end else begin
				stall_run = $urandom_range(0, 3);
			end
		end
	end

	// Every completed result transfer is matched against the oldest pending
	// frame report, field by field.
	always @(posedge clk) begin
		rfp_pkg::res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (frame_reports_q.size() == 0) begin
				report_mismatch("result with none pending, frame_length", frame_length, 0);
			end else begin
				want = frame_reports_q.pop_front();
				if (frame_accepted !== want.frame_accepted)
					report_mismatch("frame_accepted", frame_accepted, want.frame_accepted);
				if (presence !== want.presence)
					report_mismatch("presence", presence, want.presence);
				if (moving_target !== want.moving_target)
					report_mismatch("moving_target", moving_target, want.moving_target);
				if (stationary_target !== want.stationary_target)
					report_mismatch("stationary_target", stationary_target,
						want.stationary_target);
				if (target_state !== want.target_state)
					report_mismatch("target_state", target_state, want.target_state);
				if (frame_length !== want.frame_length)
					report_mismatch("frame_length", frame_length, want.frame_length);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout with %0d frame reports pending", frame_reports_q.size());
			$display("radar_frame_target_parser_tb NOT OK");
			$finish;
		end
	end

	// Accepted frames carrying each target state code, the widest state byte,
	// the longest frame that fits a pass, and a broken header that must leave
	// the held flags alone.
	task automatic test_target_states();
		send_frame(rfp_pkg::MIN_FRAME, 1'b1, rfp_pkg::TS_BOTH);
		send_frame(rfp_pkg::MIN_FRAME, 1'b1, rfp_pkg::TS_NONE);
		send_frame(rfp_pkg::MIN_FRAME, 1'b1, rfp_pkg::TS_MOVING);
		send_frame(rfp_pkg::MIN_FRAME, 1'b1, rfp_pkg::TS_STATIONARY);
		send_frame(21, 1'b0, rfp_pkg::TS_BOTH);
		send_frame(rfp_pkg::MIN_FRAME, 1'b1, 8'hFF);
		send_frame(PASS - 1, 1'b1, rfp_pkg::TS_BOTH);
		send_frame(22, 1'b1, 8'h00);
	endtask

	// Frames that end but are not accepted: a bare footer, frames too short to
	// reach the state byte, one that just reaches it and one a byte short of
	// the minimum length; then an accepted frame of exactly the minimum length.
	task automatic test_short_frames();
		send_frame(rfp_pkg::DELIM_LEN, 1'b1, rfp_pkg::TS_MOVING);
		send_frame(rfp_pkg::STATE_POS, 1'b1, rfp_pkg::TS_MOVING);
		send_frame(rfp_pkg::STATE_POS + 1, 1'b1, rfp_pkg::TS_MOVING);
		send_frame(rfp_pkg::MIN_FRAME - 1, 1'b1, rfp_pkg::TS_STATIONARY);
		send_frame(rfp_pkg::MIN_FRAME, 1'b1, rfp_pkg::TS_MOVING);
	endtask

	// A footer split across the wrap must not close a frame, and a header that
	// straddles the wrap must not count for the new pass.
	task automatic test_pass_wrap();
		for (int i = 0; i < PASS - 2; i++) begin
			send_byte((i % 2 == 0) ? 8'h00 : 8'hFF);
		end
		send_byte(rfp_pkg::FTR_B0);
		send_byte(rfp_pkg::FTR_B1);
		send_byte(rfp_pkg::FTR_B2);
		send_byte(rfp_pkg::FTR_B3);
		send_frame(8, 1'b0, rfp_pkg::TS_NONE);
		for (int i = 0; i < PASS - 2; i++) begin
			send_byte(8'h5A);
		end
		send_byte(rfp_pkg::HDR_B0);
		send_byte(rfp_pkg::HDR_B1);
		send_byte(rfp_pkg::HDR_B2);
		send_byte(rfp_pkg::HDR_B3);
		for (int i = 0; i < rfp_pkg::MIN_FRAME; i++) begin
			send_byte(8'h03);
		end
		send_byte(rfp_pkg::FTR_B0);
		send_byte(rfp_pkg::FTR_B1);
		send_byte(rfp_pkg::FTR_B2);
		send_byte(rfp_pkg::FTR_B3);
	endtask

	// The receiver holds off while a run of bare footers keeps producing
	// results, so both result slots fill and the byte input has to stall.
	task automatic test_backpressure();
		calm = 1'b1;
		hold_left = HOLD_CYCLES;
		for (int i = 0; i < 10; i++) begin
			send_frame(rfp_pkg::DELIM_LEN, 1'b0, rfp_pkg::TS_NONE);
		end
		calm = 1'b0;
	endtask

	// Mostly well-formed frames with random content, mixed with broken
	// headers and loose bytes near the delimiter values.
	task automatic test_random_traffic();
		int pick;
		int len;
		int start_bytes;
		logic [7:0] ts;
		start_bytes = bytes_sent;
		while ((bytes_sent - start_bytes) < 130) begin
			if ($urandom_range(0, 9) == 0) begin
				calm = !calm;
			end
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 19) == 0) begin
				len = $urandom_range(rfp_pkg::DELIM_LEN, rfp_pkg::MIN_FRAME - 1);
			end else if ($urandom_range(0, 9) == 0) begin
				len = $urandom_range(41, PASS - 1);
			end else begin
				len = $urandom_range(rfp_pkg::MIN_FRAME, 40);
			end
			if ($urandom_range(0, 4) == 0) begin
				ts = 8'($urandom);
			end else begin
				ts = 8'($urandom_range(0, 3));
			end
			if (pick < 70) begin
				send_frame(len, 1'b1, ts);
			end else if (pick < 85) begin
				send_frame(len, 1'b0, ts);
			end else begin
				repeat ($urandom_range(1, 10)) begin
					if ($urandom_range(0, 1) == 1) begin
						send_byte(8'($urandom_range(8'hF0, 8'hFF)));
					end else begin
						send_byte(8'($urandom));
					end
				end
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		trk_count      = 0;
		trk_hdr_ok     = 1'b0;
		trk_state      = 8'h00;
		trk_hist       = '{8'h00, 8'h00, 8'h00};
		trk_presence   = 1'b0;
		trk_moving     = 1'b0;
		trk_stationary = 1'b0;
		frames_predicted = 0;
		bytes_sent  = 0;
		errors      = 0;
		cycle_count = 0;
		calm        = 1'b0;
		hold_left   = 0;
		stall_run   = 0;

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_target_states();
		test_short_frames();
		test_pass_wrap();
		test_backpressure();
		test_random_traffic();

		@(negedge clk);
		rx_valid <= 1'b0;
		while (frame_reports_q.size() != 0) begin
			@(posedge clk);
		end
		// Waiting on after the last report has been matched shows up any stray result.
		repeat (10) @(posedge clk);

		if (errors == 0) begin
			$display("radar_frame_target_parser_tb OK");
		end else begin
			$display("radar_frame_target_parser_tb NOT OK");
		end
		$finish;
	end

endmodule
